FILE: hdl/rgb_lamp_mode_tilt_dimmer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the lamp controller checkers.
// ----------------------------------------------------------------------------
`ifndef RGB_LAMP_MODE_TILT_DIMMER_ASSERT_SVH
`define RGB_LAMP_MODE_TILT_DIMMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LAMP_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LAMP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/rlmtd_pkg.sv
// ----------------------------------------------------------------------------
// rlmtd_pkg
// Types and constants shared by the lamp controller modules.
// ----------------------------------------------------------------------------
package rlmtd_pkg;

    localparam int DUTY_W  = 10;
    localparam int MODE_W  = 3;
    localparam int TILT_W  = 16;
    localparam int TDATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_DEMO  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WHITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RED   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GREEN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RGB   = 3'd5;

    localparam logic REG_TILT_LOW  = 1'b0;
    localparam logic REG_TILT_HIGH = 1'b1;

    localparam logic ACTION_PRESS = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
        logic [DUTY_W-1:0] total;
        logic [DUTY_W-1:0] saved_red;
        logic [DUTY_W-1:0] saved_green;
        logic [DUTY_W-1:0] saved_blue;
        logic [DUTY_W-1:0] saved_total;
    } lamp_state_t;

    typedef struct packed {
        logic        action;
        logic [15:0] tilt_y;
    } lamp_event_t;

endpackage

FILE: hdl/rlmtd_step.sv
// ----------------------------------------------------------------------------
// rlmtd_step
// Next-state logic for one event: mode press or tilt brighten/dim.
// ----------------------------------------------------------------------------
module rlmtd_step
(
    input  rlmtd_pkg::lamp_state_t cur,
    input  rlmtd_pkg::lamp_event_t evt,
    input  logic signed [15:0]     tilt_low,
    input  logic signed [15:0]     tilt_high,
    output rlmtd_pkg::lamp_state_t nxt,
    output logic                   upd
);
    import rlmtd_pkg::*;

    localparam logic [12:0] AVG_RECIP = 13'd2731;
    localparam int          AVG_SHIFT = 13;

    logic [11:0] sum;
    logic [24:0] prod;
    logic [DUTY_W-1:0] avg;
    logic bright;
    logic dimming;
    lamp_state_t s;

    function automatic logic [DUTY_W-1:0] grow(input logic [DUTY_W-1:0] v);
        return {v[DUTY_W-2:0], 1'b1};
    endfunction

    function automatic logic [DUTY_W-1:0] dbl_sat(input logic [DUTY_W-1:0] v);
        return v[DUTY_W-1] ? {DUTY_W{1'b1}} : {v[DUTY_W-2:0], 1'b0};
    endfunction

    assign sum  = 12'(cur.red) + 12'(cur.green) + 12'(cur.blue);
    assign prod = 25'(sum) * 25'(AVG_RECIP);
    assign avg  = prod[AVG_SHIFT +: DUTY_W];

    assign bright  = $signed(evt.tilt_y) < tilt_low;
    assign dimming = $signed(evt.tilt_y) > tilt_high;

    always_comb
    begin
        s   = cur;
        upd = 1'b0;
        if (evt.action == ACTION_PRESS)
        begin
            if (cur.mode >= MODE_RGB)
                s.mode = MODE_DEMO;
            else
                s.mode = cur.mode + 3'd1;
            upd = (s.mode != MODE_DEMO);
            case (s.mode)
                MODE_DEMO:
                begin
                    s.saved_red   = cur.red;
                    s.saved_green = cur.green;
                    s.saved_blue  = cur.blue;
                    s.saved_total = avg;
                    s.total       = avg;
                end
                MODE_WHITE:
                begin
                    s.red   = cur.saved_total;
                    s.green = cur.saved_total;
                    s.blue  = cur.saved_total;
                end
                MODE_RED:
                begin
                    s.saved_red   = cur.red;
                    s.saved_green = cur.green;
                    s.saved_blue  = cur.blue;
                    s.saved_total = avg;
                    s.green       = '0;
                    s.blue        = '0;
                end
                MODE_GREEN:
                begin
                    s.saved_red = cur.red;
                    s.red       = '0;
                    s.green     = cur.saved_green;
                    s.blue      = '0;
                end
                MODE_BLUE:
                begin
                    s.saved_green = cur.green;
                    s.red         = '0;
                    s.green       = '0;
                    s.blue        = cur.saved_blue;
                end
                default:
                begin
                    s.saved_blue = cur.blue;
                    s.red        = cur.saved_red;
                    s.green      = cur.saved_green;
                    s.blue       = cur.blue;
                end
            endcase
        end
        else
        begin
            if (bright)
            begin
                case (cur.mode)
                    MODE_DEMO:  s.total = grow(s.total);
                    MODE_WHITE:
                    begin
                        s.total = grow(s.total);
                        s.red   = s.total;
                        s.green = s.total;
                        s.blue  = s.total;
                    end
                    MODE_RED:   s.red   = grow(s.red);
                    MODE_GREEN: s.green = grow(s.green);
                    MODE_BLUE:  s.blue  = grow(s.blue);
                    MODE_RGB:
                    begin
                        s.red   = dbl_sat(s.red);
                        s.green = dbl_sat(s.green);
                        s.blue  = dbl_sat(s.blue);
                    end
                    default: ;
                endcase
            end
            if (dimming)
            begin
                case (cur.mode)
                    MODE_DEMO:  s.total = s.total >> 1;
                    MODE_WHITE:
                    begin
                        s.total = s.total >> 1;
                        s.red   = s.total;
                        s.green = s.total;
                        s.blue  = s.total;
                    end
                    MODE_RED:   s.red   = s.red >> 1;
                    MODE_GREEN: s.green = s.green >> 1;
                    MODE_BLUE:  s.blue  = s.blue >> 1;
                    MODE_RGB:
                    begin
                        s.red   = s.red >> 1;
                        s.green = s.green >> 1;
                        s.blue  = s.blue >> 1;
                    end
                    default: ;
                endcase
            end
            upd = (bright || dimming) && (cur.mode >= MODE_WHITE) && (cur.mode <= MODE_RGB);
        end
        nxt = s;
    end

endmodule

FILE: hdl/rgb_lamp_mode_tilt_dimmer.sv
// ----------------------------------------------------------------------------
// rgb_lamp_mode_tilt_dimmer
// Six-mode RGB lamp controller driven by button presses and tilt samples.
// ----------------------------------------------------------------------------
// One request in, one result out. The block takes a request every cycle
// while the result stream is not stalled. An accepted request is loaded
// into the input register; once the result register is free, the next-state
// logic's output is loaded into the result register and lamp state. The rate
// is set by the combinational next-state path, which sees the state left by
// the previous request. The user must write thresholds through cfg_we/
// cfg_index/cfg_data while no request is in flight; the block does not enforce it.
module rgb_lamp_mode_tilt_dimmer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] tilt_y
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] mode, [12:3] red_duty, [22:13] green_duty, [32:23] blue_duty,
    // [42:33] level_total, [43] drive_update, [44] demo_run, [47:45] zero
    output logic [47:0] m_tdata
);
    import rlmtd_pkg::*;

    logic signed [15:0] tilt_low_reg,  tilt_low_next;
    logic signed [15:0] tilt_high_reg, tilt_high_next;
    logic               in_valid_reg,  in_valid_next;
    lamp_event_t        in_evt_reg,    in_evt_next;
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg,  out_data_next;
    lamp_state_t        state_reg,     state_next;
    lamp_state_t        step_state;
    logic               step_upd;
    logic               out_free;
    logic               advance;

    rlmtd_step u_step
    (
        .cur       (state_reg),
        .evt       (in_evt_reg),
        .tilt_low  (tilt_low_reg),
        .tilt_high (tilt_high_reg),
        .nxt       (step_state),
        .upd       (step_upd)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        tilt_low_next  = tilt_low_reg;
        tilt_high_next = tilt_high_reg;
        if (cfg_we && cfg_index == REG_TILT_LOW)
            tilt_low_next = cfg_data;
        if (cfg_we && cfg_index == REG_TILT_HIGH)
            tilt_high_next = cfg_data;

        in_valid_next = in_valid_reg;
        in_evt_next   = in_evt_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            in_evt_next   = '{action: s_tuser, tilt_y: s_tdata};
        end

        state_next     = advance ? step_state : state_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);
        out_data_next  = out_data_reg;
        if (advance)
            out_data_next = {3'b000,
                             step_state.mode == MODE_DEMO,
                             step_upd,
                             step_state.total,
                             step_state.blue,
                             step_state.green,
                             step_state.red,
                             step_state.mode};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_low_reg  <= -16'sd100;
            tilt_high_reg <= 16'sd100;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            tilt_low_reg  <= tilt_low_next;
            tilt_high_reg <= tilt_high_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_evt_reg   <= in_evt_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: hdl/rlmtd_checker.sv
// ----------------------------------------------------------------------------
// rlmtd_checker
// Port-level checks on the lamp controller result stream.
// ----------------------------------------------------------------------------
`include "rgb_lamp_mode_tilt_dimmer_assert.svh"

module rlmtd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import rlmtd_pkg::*;

    `LAMP_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")
    `LAMP_ASSERT_NOW(a_mode_range, m_tvalid, m_tdata[2:0] <= MODE_RGB, "mode out of range")
    `LAMP_ASSERT_NOW(a_demo_flag, m_tvalid,
        m_tdata[44] == (m_tdata[2:0] == MODE_DEMO), "demo_run disagrees with mode")
    `LAMP_ASSERT_NOW(a_demo_no_drive, m_tvalid && m_tdata[44], !m_tdata[43],
        "LED rewrite in demo mode")

endmodule

bind rgb_lamp_mode_tilt_dimmer rlmtd_checker u_rlmtd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
